FILE: rtl/core/trd_pkg.sv
// trd_pkg: beat types, op and register codes, state encoding and helpers
// for the triangle raster depth test core; no dependencies
`default_nettype none

package trd_pkg;

    // op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [10:0] RST_DIM   = 11'd700;
    localparam logic [23:0] FAR_DEPTH = 24'hFFFFFF;
    localparam logic [1:0]  LAST_SLOT = 2'd2;

    // datapath widths: products, edge values, edge sum, depth numerator
    localparam int PW = 34;
    localparam int EW = 35;
    localparam int DW = 37;
    localparam int NW = 61;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         vertex_slot;
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic [23:0]        vert_z;
    } t_in_beat;

    typedef struct packed {
        logic [9:0]  pix_x;
        logic [10:0] pix_y;
        logic        covered;
        logic        written;
        logic [23:0] frag_depth;
        logic [16:0] weight_a;
        logic [16:0] weight_b;
        logic [16:0] weight_c;
        logic        walk_done;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_EDGE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    // integer part of a 12.4 value, truncated toward zero
    function automatic logic signed [11:0] trunc_int(input logic signed [15:0] v);
        logic signed [15:0] t;
        t = v + ((v < 0) ? 16'sd15 : 16'sd0);
        return t[15:4];
    endfunction

    function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // (b0 - a0) * (c0 - d0), exact
    function automatic logic signed [PW-1:0] mul_term(input logic signed [15:0] a0,
                                                      input logic signed [15:0] b0,
                                                      input logic signed [15:0] c0,
                                                      input logic signed [15:0] d0);
        logic signed [16:0] s;
        logic signed [16:0] t;
        s = 17'(b0) - 17'(a0);
        t = 17'(c0) - 17'(d0);
        return PW'(s) * PW'(t);
    endfunction

    function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
        return (v < 0) ? EW'(-v) : EW'(v);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/triangle_raster_depth_test_core.sv
// triangle_raster_depth_test_core: edge-function rasterizer with depth store
// depends on trd_pkg and trd_div
//
//   channel | direction | handshake                  | beat
//   in      | input     | i_in_valid / o_in_ready    | t_in_beat
//   out     | output    | o_out_valid / i_out_ready  | t_out_beat
//   cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_wdata
//
// load, clear, idle step and unused ops: result taken straight into the out register
// step on an uncovered pixel: accept, edge products, sign test, finish
// step on a covered pixel: adds the bit-serial depth multiply over the three vertex
//   depths and the shared divider (depth first, then the three weights)
// after reset and after a clear op the store is swept over all MAX_WIDTH*MAX_HEIGHT entries,
//   one entry a cycle, with o_in_ready low; a full out register not being read also holds o_in_ready low
`default_nettype none

module triangle_raster_depth_test_core import trd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_beat    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_beat        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [10:0] i_cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = WW + HW + 1;

    t_state r_state, n_state;

    logic [10:0]        r_cfg_w, r_cfg_h;
    logic signed [15:0] r_vx [3];
    logic signed [15:0] r_vy [3];
    logic [23:0]        r_vz [3];
    logic signed [11:0] r_box_r, r_box_b, r_box_t;
    logic signed [11:0] r_walk_x, r_walk_y;
    logic               r_active;

    logic signed [PW-1:0] r_pa [3];
    logic signed [PW-1:0] r_pb [3];
    logic               r_onscr, r_last, r_covered;
    logic [AW-1:0]      r_addr;
    logic [EW-1:0]      r_e [3];
    logic [DW-1:0]      r_d;
    logic [NW-1:0]      r_acc, r_mm;
    logic [23:0]        r_mq;
    logic [4:0]         r_mcnt;
    logic [1:0]         r_mk;
    logic [1:0]         r_dk;
    logic               r_dstart;
    logic [23:0]        r_z;
    logic [16:0]        r_w [3];

    logic [23:0]        r_mem [DEPTH];
    logic [23:0]        r_rd;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    logic               r_out_valid;
    t_out_beat          r_out;

    logic               in_acc, out_free, fin_go, pix_wr, mem_re;
    logic               step_go, next_active;
    t_out_beat          idle_out;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic signed [15:0] px, py, xs, ys, ws, hs;
    logic signed [EW-1:0] c [3];
    logic [EW-1:0]      e_new [3];
    logic               in_tri;
    logic [HW-1:0]      row;
    logic [XW-1:0]      addr_full;
    logic [EW-1:0]      e_div;
    logic [DW-1:0]      div_rem;
    logic [23:0]        div_lo;
    logic [4:0]         div_nbits;
    logic               div_done;
    logic [23:0]        div_quot;

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !r_clr_busy && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign step_go    = in_acc && (i_in_data.op == OP_STEP) && r_active;
    assign fin_go     = (r_state == ST_FIN) && out_free;
    assign pix_wr     = fin_go && r_covered && (r_z < r_rd);
    assign mem_re     = (r_state == ST_EDGE);

    // effective screen size, walk position and store address
    always_comb begin
        w_eff = (32'(r_cfg_w) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(r_cfg_w);
        h_eff = (32'(r_cfg_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_cfg_h);
        xs    = 16'(r_walk_x);
        ys    = 16'(r_walk_y);
        ws    = signed'(16'(w_eff));
        hs    = signed'(16'(h_eff));
        px    = {r_walk_x, 4'b1000};
        py    = {r_walk_y, 4'b1000};
        row   = HW'(h_eff) - HW'(r_walk_y);
        addr_full = XW'(row) * XW'(w_eff) + XW'(r_walk_x);
    end

    // edge values, sign test and magnitudes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c[k] = EW'(r_pa[k]) - EW'(r_pb[k]);
        end
        in_tri = (c[0] > 0 && c[1] > 0 && c[2] > 0) || (c[0] < 0 && c[1] < 0 && c[2] < 0);
        e_new[0] = mag(c[1]);
        e_new[1] = mag(c[2]);
        e_new[2] = mag(c[0]);
    end

    // next active flag for a non-walking result
    always_comb begin
        next_active = r_active;
        case (i_in_data.op)
            OP_LOAD: begin
                if (i_in_data.vertex_slot == LAST_SLOT) begin
                    next_active = 1'b1;
                end else if (i_in_data.vertex_slot < LAST_SLOT) begin
                    next_active = 1'b0;
                end
            end
            default: next_active = r_active;
        endcase
    end

    // result beat for a non-walking input
    always_comb begin
        idle_out           = '0;
        idle_out.walk_done = (i_in_data.op == OP_STEP) ? 1'b1 : !next_active;
    end

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (step_go) n_state = ST_PROD;
            ST_PROD: n_state = ST_EDGE;
            ST_EDGE: n_state = (in_tri && r_onscr) ? ST_MUL : ST_FIN;
            ST_MUL:  if (r_mcnt == 5'd23 && r_mk == LAST_SLOT) n_state = ST_DIV;
            ST_DIV:  if (div_done && r_dk == 2'd3) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_DIM;
            r_cfg_h <= RST_DIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_cfg_w <= i_cfg_wdata;
                REG_HEIGHT: r_cfg_h <= i_cfg_wdata;
                default:    r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    // vertex store
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.op == OP_LOAD && i_in_data.vertex_slot <= LAST_SLOT) begin
            r_vx[i_in_data.vertex_slot] <= i_in_data.vert_x;
            r_vy[i_in_data.vertex_slot] <= i_in_data.vert_y;
            r_vz[i_in_data.vertex_slot] <= i_in_data.vert_z;
        end
    end

    // bounding box, walk position and active flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_r  <= '0;
            r_box_b  <= '0;
            r_box_t  <= '0;
            r_walk_x <= '0;
            r_walk_y <= '0;
            r_active <= 1'b0;
        end else if (in_acc && i_in_data.op == OP_LOAD) begin
            r_active <= next_active;
            if (i_in_data.vertex_slot == LAST_SLOT) begin
                r_walk_x <= trunc_int(min3(r_vx[0], r_vx[1], i_in_data.vert_x));
                r_box_r  <= trunc_int(max3(r_vx[0], r_vx[1], i_in_data.vert_x));
                r_walk_y <= trunc_int(min3(r_vy[0], r_vy[1], i_in_data.vert_y));
                r_box_b  <= trunc_int(min3(r_vy[0], r_vy[1], i_in_data.vert_y));
                r_box_t  <= trunc_int(max3(r_vy[0], r_vy[1], i_in_data.vert_y));
            end
        end else if (fin_go) begin
            if (r_last) begin
                r_active <= 1'b0;
            end else if (r_walk_y >= r_box_t) begin
                r_walk_y <= r_box_b;
                r_walk_x <= r_walk_x + 12'sd1;
            end else begin
                r_walk_y <= r_walk_y + 12'sd1;
            end
        end
    end

    // edge products, screen test and store address
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PROD) begin
            r_pa[0] <= mul_term(r_vx[0], r_vx[1], py, r_vy[0]);
            r_pb[0] <= mul_term(r_vy[0], r_vy[1], px, r_vx[0]);
            r_pa[1] <= mul_term(r_vx[1], r_vx[2], py, r_vy[1]);
            r_pb[1] <= mul_term(r_vy[1], r_vy[2], px, r_vx[1]);
            r_pa[2] <= mul_term(r_vx[2], r_vx[0], py, r_vy[2]);
            r_pb[2] <= mul_term(r_vy[2], r_vy[0], px, r_vx[2]);
            r_onscr <= (xs >= 0) && (xs < ws) && (ys >= 16'sd1) && (ys <= hs);
            r_last  <= (r_walk_x == r_box_r) && (r_walk_y == r_box_t);
            r_addr  <= addr_full[AW-1:0];
        end
    end

    // coverage, weights source and depth multiply, one z bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EDGE) begin
            r_covered <= in_tri && r_onscr;
            r_e[0]    <= e_new[0];
            r_e[1]    <= e_new[1];
            r_e[2]    <= e_new[2];
            r_d       <= DW'(e_new[0]) + DW'(e_new[1]) + DW'(e_new[2]);
            r_acc     <= '0;
            r_mm      <= NW'(e_new[0]);
            r_mq      <= r_vz[0];
            r_mcnt    <= '0;
            r_mk      <= '0;
        end else if (r_state == ST_MUL) begin
            if (r_mq[0]) begin
                r_acc <= r_acc + r_mm;
            end
            if (r_mcnt == 5'd23) begin
                r_mcnt <= '0;
                r_mk   <= r_mk + 2'd1;
                r_mm   <= (r_mk == 2'd0) ? NW'(r_e[1]) : NW'(r_e[2]);
                r_mq   <= (r_mk == 2'd0) ? r_vz[1] : r_vz[2];
            end else begin
                r_mcnt <= r_mcnt + 5'd1;
                r_mm   <= {r_mm[NW-2:0], 1'b0};
                r_mq   <= {1'b0, r_mq[23:1]};
            end
        end
    end

    // divider sequencing: depth first, then the three weights
    always_comb begin
        case (r_dk)
            2'd1:    e_div = r_e[0];
            2'd2:    e_div = r_e[1];
            default: e_div = r_e[2];
        endcase
        if (r_dk == 2'd0) begin
            div_rem   = r_acc[NW-1:24];
            div_lo    = r_acc[23:0];
            div_nbits = 5'd24;
        end else begin
            div_rem   = DW'(e_div[EW-1:1]);
            div_lo    = {e_div[0], 23'd0};
            div_nbits = 5'd17;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dstart <= 1'b0;
            r_dk     <= '0;
        end else begin
            r_dstart <= 1'b0;
            if (r_state == ST_MUL && n_state == ST_DIV) begin
                r_dstart <= 1'b1;
                r_dk     <= '0;
            end else if (r_state == ST_DIV && div_done) begin
                r_dk <= r_dk + 2'd1;
                if (r_dk != 2'd3) begin
                    r_dstart <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && div_done) begin
            case (r_dk)
                2'd0:    r_z    <= div_quot;
                2'd1:    r_w[0] <= div_quot[16:0];
                2'd2:    r_w[1] <= div_quot[16:0];
                default: r_w[2] <= div_quot[16:0];
            endcase
        end
    end

    trd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_nbits (div_nbits),
        .i_rem   (div_rem),
        .i_lo    (div_lo),
        .i_div   (r_d),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // clearing sweep after reset and on a clear op
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (in_acc && i_in_data.op == OP_CLEAR) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // depth store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= FAR_DEPTH;
        end else if (pix_wr) begin
            r_mem[r_addr] <= r_z;
        end
        if (mem_re) begin
            r_rd <= r_mem[r_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((in_acc && !step_go) || fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out.pix_x      <= r_walk_x[9:0];
            r_out.pix_y      <= r_walk_y[10:0];
            r_out.covered    <= r_covered;
            r_out.written    <= pix_wr;
            r_out.frag_depth <= r_covered ? r_z : 24'd0;
            r_out.weight_a   <= r_covered ? r_w[0] : 17'd0;
            r_out.weight_b   <= r_covered ? r_w[1] : 17'd0;
            r_out.weight_c   <= r_covered ? r_w[2] : 17'd0;
            r_out.walk_done  <= r_last;
        end else if (in_acc && !step_go) begin
            r_out <= idle_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("input accepted during store sweep");

    a_mul_only_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> r_covered)
        else $error("depth multiply on an uncovered pixel");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its state");

    a_active_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_active) |-> $past(in_acc))
        else $error("walk started without an accepted beat");

endmodule

`default_nettype wire

FILE: rtl/core/trd_div.sv
// trd_div: restoring divider, one quotient bit per cycle
// depends on trd_pkg for the divisor width
`default_nettype none

module trd_div import trd_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [4:0]    i_nbits,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [23:0]   i_lo,
    input  wire logic [DW-1:0] i_div,
    output logic               o_done,
    output logic [23:0]        o_quot
);

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [23:0]   r_lo;
    logic [23:0]   r_q;
    logic [DW:0]   trial;
    logic          fits;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_lo[23]};
        fits  = (trial >= {1'b0, i_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_lo  <= i_lo;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, i_div}) : DW'(trial);
            r_lo  <= {r_lo[22:0], 1'b0};
            r_q   <= {r_q[22:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire
